### sv/crx_pkg.sv
`timescale 1ns / 1ps

package crx_pkg;

  localparam int LENGTH_DIGITS_DEF = 3;
  localparam int SUM_DIGITS_DEF    = 6;
  localparam int BLOCK_DIGITS      = 3;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] START_ESC  = 8'h9b;
  localparam logic [6:0] CHAR_T     = 7'h54;
  localparam logic [6:0] CHAR_Q     = 7'h51;
  localparam logic [6:0] CHAR_ESC   = 7'h1b;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] TYPE_DATA  = 7'h00;

  localparam logic [2:0] EV_DATA    = 3'd0;
  localparam logic [2:0] EV_OK      = 3'd1;
  localparam logic [2:0] EV_BADSUM  = 3'd2;
  localparam logic [2:0] EV_BADBLK  = 3'd3;
  localparam logic [2:0] EV_FRAME   = 3'd4;
  localparam logic [2:0] EV_TIMEOUT = 3'd5;
  localparam logic [2:0] EV_END     = 3'd6;

  // A received item after classification by the front.
  typedef struct packed {
    logic       err;
    logic       is_start;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] b7;
  } crx_item_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic      valid;
    crx_item_t item;
  } crx_head_t;

endpackage

### sv/crx_front.sv
`timescale 1ns / 1ps

module crx_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              rx_error,
  input  logic              queue_full,
  output logic              push,
  output crx_pkg::crx_item_t push_item
);
  import crx_pkg::*;

  logic [6:0] b7;

  assign b7       = rx_byte[6:0];
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_item.err      = rx_error;
    push_item.is_start = (rx_byte == START_ESC);
    push_item.is_digit = (b7 >= CHAR_ZERO) && (b7 <= CHAR_NINE);
    push_item.digit    = 4'(b7 - CHAR_ZERO);
    push_item.b7       = b7;
  end

endmodule

### sv/crx_queue.sv
`timescale 1ns / 1ps

module crx_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crx_pkg::crx_item_t push_item,
  output logic               full,
  input  logic               pop,
  output crx_pkg::crx_head_t head
);
  import crx_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  crx_item_t       mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/crx_back.sv
`timescale 1ns / 1ps

module crx_back #(
  parameter int LENGTH_DIGITS = crx_pkg::LENGTH_DIGITS_DEF,
  parameter int SUM_DIGITS    = crx_pkg::SUM_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  crx_pkg::crx_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_res,
  output logic [6:0]         data_byte,
  output logic [6:0]         header_block,
  output logic [9:0]         block_length
);
  import crx_pkg::*;

  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_T    = 4'd1;
  localparam logic [3:0] PH_TYPE = 4'd2;
  localparam logic [3:0] PH_QUIT = 4'd3;
  localparam logic [3:0] PH_LEN  = 4'd4;
  localparam logic [3:0] PH_BLK  = 4'd5;
  localparam logic [3:0] PH_DATA = 4'd6;
  localparam logic [3:0] PH_SUM  = 4'd7;
  localparam logic [3:0] PH_HALT = 4'd8;

  logic [3:0]  phase, phase_next;
  logic [9:0]  field_count, field_count_next;
  logic [9:0]  length_value, length_value_next;
  logic [6:0]  remote_block, remote_block_next;
  logic        block_over, block_over_next;
  logic [6:0]  expected_block, expected_block_next;
  logic [16:0] running_sum, running_sum_next;
  logic [19:0] remote_sum, remote_sum_next;
  logic        digits_ended, digits_ended_next;

  logic        take;
  logic        res_valid;
  logic [2:0]  res_event;
  logic [6:0]  res_data;
  logic [10:0] count_inc;
  logic [13:0] len_x10;
  logic [10:0] blk_x10;
  logic [23:0] sum_x10;
  crx_item_t   it;

  assign it   = head.item;
  assign take = head.valid && (!out_valid || out_ready);
  assign pop  = take;

  // Decimal accumulation: value * 10 + digit, by shifts and adds.
  assign count_inc = {1'b0, field_count} + 11'd1;
  assign len_x10   = ({4'b0, length_value} << 3) + ({4'b0, length_value} << 1)
                     + {10'b0, it.digit};
  assign blk_x10   = ({4'b0, remote_block} << 3) + ({4'b0, remote_block} << 1)
                     + {7'b0, it.digit};
  assign sum_x10   = ({4'b0, remote_sum} << 3) + ({4'b0, remote_sum} << 1)
                     + {20'b0, it.digit};

  always_comb begin
    phase_next          = phase;
    field_count_next    = field_count;
    length_value_next   = length_value;
    remote_block_next   = remote_block;
    block_over_next     = block_over;
    expected_block_next = expected_block;
    running_sum_next    = running_sum;
    remote_sum_next     = remote_sum;
    digits_ended_next   = digits_ended;
    res_valid           = 1'b0;
    res_event           = EV_DATA;
    res_data            = '0;

    if (take && phase != PH_HALT) begin
      if (it.err) begin
        phase_next = PH_HALT;
        res_valid  = 1'b1;
        res_event  = EV_TIMEOUT;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (it.is_start) begin
              phase_next = PH_T;
            end
          end
          PH_T: begin
            if (it.b7 == CHAR_T) begin
              phase_next = PH_TYPE;
            end else begin
              phase_next = PH_HALT;
              res_valid  = 1'b1;
              res_event  = EV_FRAME;
            end
          end
          PH_TYPE: begin
            if (it.b7 == TYPE_DATA) begin
              length_value_next = '0;
              remote_block_next = '0;
              block_over_next   = 1'b0;
              running_sum_next  = '0;
              remote_sum_next   = '0;
              field_count_next  = '0;
              digits_ended_next = 1'b0;
              phase_next        = PH_LEN;
            end else if (it.b7 == CHAR_ESC) begin
              phase_next = PH_QUIT;
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_QUIT: begin
            if (it.b7 == CHAR_Q) begin
              phase_next = PH_HALT;
              res_valid  = 1'b1;
              res_event  = EV_END;
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_LEN: begin
            if (!digits_ended) begin
              if (it.is_digit) begin
                length_value_next = (len_x10 > 14'd1023) ? 10'd1023 : len_x10[9:0];
              end else begin
                digits_ended_next = 1'b1;
              end
            end
            field_count_next = count_inc[9:0];
            if (count_inc >= 11'(LENGTH_DIGITS)) begin
              phase_next        = PH_BLK;
              field_count_next  = '0;
              digits_ended_next = 1'b0;
            end
          end
          PH_BLK: begin
            if (!digits_ended) begin
              if (it.is_digit) begin
                // Once the number reaches 128 it stays out of range.
                if (block_over || blk_x10 >= 11'd128) begin
                  block_over_next   = 1'b1;
                  remote_block_next = '0;
                end else begin
                  remote_block_next = blk_x10[6:0];
                end
              end else begin
                digits_ended_next = 1'b1;
              end
            end
            field_count_next = count_inc[9:0];
            if (count_inc >= 11'(BLOCK_DIGITS)) begin
              phase_next        = (length_value == '0) ? PH_SUM : PH_DATA;
              field_count_next  = '0;
              digits_ended_next = 1'b0;
            end
          end
          PH_DATA: begin
            running_sum_next = running_sum + {10'b0, it.b7};
            field_count_next = count_inc[9:0];
            if (count_inc >= {1'b0, length_value}) begin
              phase_next        = PH_SUM;
              field_count_next  = '0;
              digits_ended_next = 1'b0;
            end
            res_valid = 1'b1;
            res_event = EV_DATA;
            res_data  = it.b7;
          end
          PH_SUM: begin
            if (!digits_ended) begin
              if (it.is_digit) begin
                remote_sum_next = (sum_x10 > 24'hfffff) ? 20'hfffff : sum_x10[19:0];
              end else begin
                digits_ended_next = 1'b1;
              end
            end
            field_count_next = count_inc[9:0];
            if (count_inc >= 11'(SUM_DIGITS)) begin
              field_count_next  = '0;
              digits_ended_next = 1'b0;
              res_valid         = 1'b1;
              if (remote_sum_next != {3'b0, running_sum}) begin
                phase_next = PH_HALT;
                res_event  = EV_BADSUM;
              end else if (block_over || remote_block != expected_block) begin
                phase_next = PH_HALT;
                res_event  = EV_BADBLK;
              end else begin
                expected_block_next = (expected_block == 7'd127) ? 7'd1
                                                                  : expected_block + 7'd1;
                phase_next = PH_HUNT;
                res_event  = EV_OK;
              end
            end
          end
          default: begin
            phase_next = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      field_count    <= '0;
      length_value   <= '0;
      remote_block   <= '0;
      block_over     <= 1'b0;
      expected_block <= 7'd1;
      running_sum    <= '0;
      remote_sum     <= '0;
      digits_ended   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      field_count    <= field_count_next;
      length_value   <= length_value_next;
      remote_block   <= remote_block_next;
      block_over     <= block_over_next;
      expected_block <= expected_block_next;
      running_sum    <= running_sum_next;
      remote_sum     <= remote_sum_next;
      digits_ended   <= digits_ended_next;
      if (take && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The header fields shown are those held when the result is produced.
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      event_res    <= res_event;
      data_byte    <= res_data;
      header_block <= remote_block;
      block_length <= length_value;
    end
  end

endmodule

### sv/checked_block_receiver_core.sv
`timescale 1ns / 1ps

// Channel   Signals                                       Direction
// input     in_valid, in_ready, rx_byte, rx_error         into the block
// output    out_valid, out_ready, event_res, data_byte,   out of the block
//           header_block, block_length
//
// One item per cycle is taken in steady state while the output is not stalled;
// each item passes the queue write, then the state update in the back, before its result.
// Reset clears the queue, the receive state and the output register at once.
// A stalled output stops the back only; the four-entry queue keeps the input
// open until it fills. After a terminal event every item is consumed silently.
module checked_block_receiver_core #(
  parameter int LENGTH_DIGITS = crx_pkg::LENGTH_DIGITS_DEF,
  parameter int SUM_DIGITS    = crx_pkg::SUM_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       rx_error,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [6:0] data_byte,
  output logic [6:0] header_block,
  output logic [9:0] block_length
);
  import crx_pkg::*;

  logic      queue_full;
  logic      push;
  crx_item_t push_item;
  logic      pop;
  crx_head_t head;

  crx_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .rx_error   (rx_error),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  crx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  crx_back #(
    .LENGTH_DIGITS (LENGTH_DIGITS),
    .SUM_DIGITS    (SUM_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .header_block (header_block),
    .block_length (block_length)
  );

endmodule

### sv/crx_checker.sv
`timescale 1ns / 1ps

module crx_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [6:0] data_byte,
  input logic [6:0] header_block,
  input logic [9:0] block_length
);
  import crx_pkg::*;

  logic terminal;

  assign terminal = (event_res == EV_BADSUM) || (event_res == EV_BADBLK) ||
                    (event_res == EV_FRAME) || (event_res == EV_TIMEOUT) ||
                    (event_res == EV_END);

  // Nothing can come out in the cycle right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(data_byte)
      && $stable(header_block) && $stable(block_length))
    else $error("stalled result changed");

  // Only data items carry a payload byte, and only for a non-empty packet.
  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_DATA |-> data_byte == 7'd0)
    else $error("payload byte on a non-data item");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_DATA |-> block_length != 10'd0)
    else $error("data item in a zero-length packet");

  // After a terminal event has been taken the block stays silent.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && terminal |=> !out_valid)
    else $error("result after a terminal event");

endmodule

bind checked_block_receiver_core crx_checker u_crx_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_res    (event_res),
  .data_byte    (data_byte),
  .header_block (header_block),
  .block_length (block_length)
);

### dv/checked_block_receiver_core_tb.sv
`timescale 1ns / 1ps

module checked_block_receiver_core_tb;
  import crx_pkg::*;

  localparam int LEN_DIGITS  = LENGTH_DIGITS_DEF;
  localparam int CHK_DIGITS  = SUM_DIGITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    S_HUNT, S_T, S_TYPE, S_QUIT, S_LEN, S_BLK, S_DATA, S_SUM, S_HALT
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] octet;
    logic       err;
    logic       drain;
  } line_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] data;
    logic [6:0] blk;
    logic [9:0] len;
  } rx_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       rx_error = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_res;
  logic [6:0] data_byte;
  logic [6:0] header_block;
  logic [9:0] block_length;

  line_item_t line_queue[$];
  rx_event_t  expected_events[$];
  int         mismatches = 0;
  int         cycles = 0;

  // Receiver state as the predictor sees it.
  rx_phase_e ph = S_HUNT;
  int        fcount = 0;
  int        len_val = 0;
  int        rblk = 0;
  logic      blk_over = 1'b0;
  int        exp_blk = 1;
  int        rsum = 0;
  int        rem_sum = 0;
  logic      dig_end = 1'b0;

  // Stimulus generator bookkeeping.
  int gen_block = 1;
  int packets_sent = 0;

  checked_block_receiver_core #(
    .LENGTH_DIGITS(LEN_DIGITS),
    .SUM_DIGITS   (CHK_DIGITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .rx_error    (rx_error),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .data_byte   (data_byte),
    .header_block(header_block),
    .block_length(block_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("checked_block_receiver_core_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int fold_digit(int acc, int b, int cap);
    int v;
    if (dig_end) return acc;
    if (b < CHAR_ZERO || b > CHAR_NINE) begin
      dig_end = 1'b1;
      return acc;
    end
    v = acc * 10 + (b - CHAR_ZERO);
    return (v > cap) ? cap : v;
  endfunction

  function automatic void open_field(rx_phase_e nxt);
    ph      = nxt;
    fcount  = 0;
    dig_end = 1'b0;
  endfunction

  function automatic void note_event(logic [2:0] kind, logic [6:0] data);
    rx_event_t e;
    e.kind = kind;
    e.data = data;
    e.blk  = rblk[6:0];
    e.len  = len_val[9:0];
    expected_events.push_back(e);
  endfunction

  function automatic void predict_item(logic [7:0] octet, logic err);
    int b;
    int acc;
    b = int'(octet[6:0]);
    if (ph == S_HALT) return;
    if (err) begin
      ph = S_HALT;
      note_event(EV_TIMEOUT, 7'd0);
      return;
    end
    case (ph)
      S_HUNT: begin
        if (octet == START_ESC) ph = S_T;
      end
      S_T: begin
        if (b == CHAR_T) begin
          ph = S_TYPE;
        end else begin
          ph = S_HALT;
          note_event(EV_FRAME, 7'd0);
        end
      end
      S_TYPE: begin
        if (b == TYPE_DATA) begin
          len_val  = 0;
          rblk     = 0;
          blk_over = 1'b0;
          rsum     = 0;
          rem_sum  = 0;
          open_field(S_LEN);
        end else if (b == CHAR_ESC) begin
          ph = S_QUIT;
        end else begin
          ph = S_HUNT;
        end
      end
      S_QUIT: begin
        if (b == CHAR_Q) begin
          ph = S_HALT;
          note_event(EV_END, 7'd0);
        end else begin
          ph = S_HUNT;
        end
      end
      S_LEN: begin
        len_val = fold_digit(len_val, b, 1023);
        fcount++;
        if (fcount >= LEN_DIGITS) open_field(S_BLK);
      end
      S_BLK: begin
        // Once the block number has gone past 127 it stays invalid for this packet.
        acc = blk_over ? 128 : rblk;
        acc = fold_digit(acc, b, 128);
        if (acc >= 128) begin
          blk_over = 1'b1;
          rblk     = 0;
        end else begin
          rblk = acc;
        end
        fcount++;
        if (fcount >= BLOCK_DIGITS) open_field((len_val == 0) ? S_SUM : S_DATA);
      end
      S_DATA: begin
        rsum = (rsum + b) & 'h1ffff;
        fcount++;
        if (fcount >= len_val) open_field(S_SUM);
        note_event(EV_DATA, b[6:0]);
      end
      S_SUM: begin
        rem_sum = fold_digit(rem_sum, b, 'hfffff);
        fcount++;
        if (fcount >= CHK_DIGITS) begin
          fcount  = 0;
          dig_end = 1'b0;
          if (rem_sum != rsum) begin
            ph = S_HALT;
            note_event(EV_BADSUM, 7'd0);
          end else if (blk_over || rblk != exp_blk) begin
            ph = S_HALT;
            note_event(EV_BADBLK, 7'd0);
          end else begin
            exp_blk++;
            if (exp_blk >= 128) exp_blk = 1;
            ph = S_HUNT;
            note_event(EV_OK, 7'd0);
          end
        end
      end
      default: ph = S_HALT;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_line(logic [7:0] octet, logic err);
    line_item_t it;
    it.octet = octet;
    it.err   = err;
    it.drain = 1'b0;
    line_queue.push_back(it);
  endtask

  function automatic logic [7:0] junk_char();
    logic [6:0] c;
    logic       top;
    c = 7'($urandom_range(0, 127));
    while (c >= CHAR_ZERO && c <= CHAR_NINE) c = 7'($urandom_range(0, 127));
    top = 1'($urandom_range(0, 1));
    return {top, c};
  endfunction

  function automatic logic [7:0] digit_char(int d);
    logic [6:0] c;
    logic       top;
    c   = 7'(CHAR_ZERO + d);
    top = 1'($urandom_range(0, 1));
    return {top, c};
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (v == START_ESC) v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // A decimal field: zero padded, or short and closed by non-digits.
  task automatic add_number(int value, int width);
    int digits[$];
    int v;
    int mode;
    v = value;
    do begin
      digits.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    mode = $urandom_range(0, 3);
    if (value == 0 && mode == 1) begin
      repeat (width) push_line(junk_char(), 1'b0);
      return;
    end
    if (mode == 0) while (digits.size() < width) digits.push_front(0);
    foreach (digits[k]) push_line(digit_char(digits[k]), 1'b0);
    repeat (width - digits.size()) push_line(junk_char(), 1'b0);
  endtask

  task automatic add_packet(int length, int blk, int sum_skew);
    int         sum;
    logic [7:0] v;
    logic       top;
    sum = 0;
    push_line(START_ESC, 1'b0);
    top = 1'($urandom_range(0, 1));
    push_line({top, CHAR_T}, 1'b0);
    top = 1'($urandom_range(0, 1));
    push_line({top, TYPE_DATA}, 1'b0);
    add_number(length, LEN_DIGITS);
    add_number(blk, BLOCK_DIGITS);
    repeat (length) begin
      v = 8'($urandom_range(0, 255));
      sum += int'(v[6:0]);
      push_line(v, 1'b0);
    end
    add_number(sum + sum_skew, CHK_DIGITS);
  endtask

  task automatic add_good_packet(int length);
    add_packet(length, gen_block, 0);
    packets_sent++;
    gen_block++;
    if (gen_block >= 128) gen_block = 1;
  endtask

  // Start escape and 'T' followed by an unknown type, or by ESC without 'Q'.
  task automatic add_abort();
    logic [6:0] c;
    logic       top;
    top = 1'($urandom_range(0, 1));
    push_line(START_ESC, 1'b0);
    push_line({top, CHAR_T}, 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      c = 7'($urandom_range(1, 127));
      while (c == CHAR_ESC) c = 7'($urandom_range(1, 127));
      push_line({top, c}, 1'b0);
    end else begin
      push_line({top, CHAR_ESC}, 1'b0);
      c = 7'($urandom_range(0, 127));
      while (c == CHAR_Q) c = 7'($urandom_range(0, 127));
      push_line({top, c}, 1'b0);
    end
  endtask

  task automatic add_drain();
    line_item_t it;
    it.octet = 8'h00;
    it.err   = 1'b0;
    it.drain = 1'b1;
    line_queue.push_back(it);
  endtask

  task automatic add_terminal();
    logic [6:0] c;
    int         pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0: begin
        push_line(START_ESC, 1'b0);
        push_line({1'b0, CHAR_T}, 1'b0);
        push_line({1'b0, TYPE_DATA}, 1'b0);
        push_line(digit_char(5), 1'b0);
        push_line(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        push_line(START_ESC, 1'b0);
        c = 7'($urandom_range(0, 127));
        while (c == CHAR_T) c = 7'($urandom_range(0, 127));
        push_line({1'b1, c}, 1'b0);
      end
      2: add_packet($urandom_range(0, 6), gen_block, $urandom_range(1, 500));
      3: add_packet($urandom_range(0, 6), (gen_block + $urandom_range(1, 126)) % 128, 0);
      4: add_packet($urandom_range(0, 6), $urandom_range(128, 999), 0);
      default: begin
        push_line(START_ESC, 1'b0);
        push_line({1'b0, CHAR_T}, 1'b0);
        push_line({1'b1, CHAR_ESC}, 1'b0);
        push_line({1'b0, CHAR_Q}, 1'b0);
      end
    endcase
    // Once halted the block must swallow everything, error flags included.
    for (int i = 0; i < 8; i++) push_line(8'($urandom_range(0, 255)), i[0]);
  endtask

  initial begin
    int r;
    // Hunting: only the full 0x9B byte counts, so 0x1B is ignored here.
    push_line(8'h00, 1'b0);
    push_line(8'hff, 1'b0);
    push_line(8'h1b, 1'b0);
    push_line(8'h7f, 1'b0);
    // Unknown type byte drops back to hunting.
    push_line(START_ESC, 1'b0);
    push_line({1'b0, CHAR_T}, 1'b0);
    push_line(8'h85, 1'b0);
    // ESC not followed by 'Q' drops back to hunting.
    push_line(START_ESC, 1'b0);
    push_line({1'b1, CHAR_T}, 1'b0);
    push_line({1'b1, CHAR_ESC}, 1'b0);
    push_line({1'b0, 7'h50}, 1'b0);
    // Zero length packet: the checksum follows the header directly.
    add_good_packet(0);
    add_drain();

    while (line_queue.size() < 1600) begin
      r = $urandom_range(0, 9);
      if (packets_sent == 30) add_good_packet(999);
      else if (packets_sent == 20 && r == 0) add_drain();
      if (r == 0) repeat ($urandom_range(1, 5)) push_line(noise_char(), 1'b0);
      else if (r == 1) add_abort();
      else if (r == 2) add_good_packet($urandom_range(7, 60));
      else add_good_packet($urandom_range(0, 6));
    end
    add_drain();
    add_terminal();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (line_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("checked_block_receiver_core_tb: done, clean");
    end else begin
      $display("checked_block_receiver_core_tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- sender

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    line_item_t nxt;
    logic       take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) predict_item(rx_byte, rx_error);
      if (!in_valid || take) begin
        // A drain mark holds the line until every outstanding result is back.
        if (line_queue.size() > 0 && line_queue[0].drain && expected_events.size() == 0)
          void'(line_queue.pop_front());
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_queue.size() > 0 && !line_queue[0].drain) begin
          nxt = line_queue.pop_front();
          rx_byte  <= nxt.octet;
          rx_error <= nxt.err;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int stall_mode = 0;
  int mode_left = 0;
  int pattern_count = 0;
  int hold_left = 0;
  int data_seen = 0;

  always @(posedge clk) begin
    rx_event_t got;
    rx_event_t want;
    if (!rst && out_valid && out_ready) begin
      got = {event_res, data_byte, header_block, block_length};
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_res %0d", got.kind);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (got.kind != want.kind) begin
          $error("event_res mismatch: expected %0d, actual %0d", want.kind, got.kind);
          mismatches++;
        end
        if (got.data != want.data) begin
          $error("data_byte mismatch: expected %0d, actual %0d", want.data, got.data);
          mismatches++;
        end
        if (got.blk != want.blk) begin
          $error("header_block mismatch: expected %0d, actual %0d", want.blk, got.blk);
          mismatches++;
        end
        if (got.len != want.len) begin
          $error("block_length mismatch: expected %0d, actual %0d", want.len, got.len);
          mismatches++;
        end
      end
      // Long hold-offs in the middle of payload, so that the queue fills.
      if (got.kind == EV_DATA) begin
        data_seen++;
        if (data_seen == 150 || data_seen == 600) hold_left = 100;
      end
    end

    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      pattern_count++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((pattern_count % 7) < 4);
      endcase
    end
  end

endmodule

### checked_block_receiver_core.f
sv/crx_pkg.sv
sv/crx_front.sv
sv/crx_queue.sv
sv/crx_back.sv
sv/checked_block_receiver_core.sv
sv/crx_checker.sv
dv/checked_block_receiver_core_tb.sv
